// ----- rtl/qlt_pkg.sv -----
// Shared types and constants for the Q table update block.
// Used by qlt_front, qlt_back and the top level; depends on nothing.
package qlt_pkg;

    localparam int MAX_X       = 16;
    localparam int MAX_Y       = 16;
    localparam int MAX_ACTIONS = 8;
    localparam int Q_WIDTH     = 24;
    localparam int X_W         = $clog2(MAX_X);
    localparam int Y_W         = $clog2(MAX_Y);
    localparam int A_W         = $clog2(MAX_ACTIONS);
    localparam int ADDR_W      = X_W + Y_W + A_W;
    localparam int DEPTH       = MAX_X * MAX_Y * MAX_ACTIONS;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam logic [12:0] ONE_Q012 = 13'd4096;

    localparam logic [2:0] REG_LEARN_RATE = 3'd0;
    localparam logic [2:0] REG_DISCOUNT   = 3'd1;
    localparam logic [2:0] REG_ACTIONS    = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_HEIGHT     = 3'd4;

    typedef enum logic [1:0] {
        MODE_LEARN = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_BEST  = 2'd3
    } mode_t;

    // Command passed from front to back: indexes already checked and sizes clamped.
    typedef struct packed {
        mode_t               mode;
        logic                bad;
        logic [ADDR_W-1:0]   cur_addr;
        logic [X_W+Y_W-1:0]  next_row;
        logic [A_W:0]        num_act;
        logic [12:0]         alpha;
        logic [12:0]         gamma;
        logic signed [Q_WIDTH-1:0] data;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_OLD_RD,
        ST_OLD,
        ST_MUL_G,
        ST_MUL_A,
        ST_SAT,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/qlt_front.sv -----
// Front end: accepts words, checks indexes against the sizes in use, builds a command.
// Depends on qlt_pkg.
module qlt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    mode,
    input  logic [2:0]                    act,
    input  logic [3:0]                    cur_x,
    input  logic [3:0]                    cur_y,
    input  logic [3:0]                    next_x,
    input  logic [3:0]                    next_y,
    input  logic signed [23:0]            data_value,
    input  logic [12:0]                   learn_rate,
    input  logic [12:0]                   discount,
    input  logic [3:0]                    actions_in_use,
    input  logic [4:0]                    grid_width,
    input  logic [4:0]                    grid_height,
    output logic                          cmd_valid,
    output qlt_pkg::cmd_t                 cmd,
    input  logic                          cmd_take
);

    logic [4:0] wx;
    logic [4:0] wy;
    logic [3:0] na;
    logic       cur_ok;
    logic       act_ok;
    logic       nxt_ok;
    logic       bad;
    qlt_pkg::cmd_t new_cmd;
    qlt_pkg::cmd_t fifo_reg [qlt_pkg::FIFO_DEPTH];
    logic [qlt_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [qlt_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [qlt_pkg::FIFO_AW:0]   count_reg;
    logic [qlt_pkg::FIFO_AW:0]   count_next;
    logic                        do_push;

    always_comb
    begin
        wx = (grid_width  > 5'd16) ? 5'd16 : grid_width;
        wy = (grid_height > 5'd16) ? 5'd16 : grid_height;
        na = (actions_in_use > 4'd8) ? 4'd8 : actions_in_use;
        cur_ok = ({1'b0, cur_x} < wx) && ({1'b0, cur_y} < wy);
        act_ok = ({1'b0, act} < na);
        nxt_ok = ({1'b0, next_x} < wx) && ({1'b0, next_y} < wy);
        case (qlt_pkg::mode_t'(mode))
            qlt_pkg::MODE_LEARN: bad = !(cur_ok && act_ok && nxt_ok);
            qlt_pkg::MODE_WRITE,
            qlt_pkg::MODE_READ:  bad = !(cur_ok && act_ok);
            qlt_pkg::MODE_BEST:  bad = !cur_ok || (na == 4'd0);
            default:             bad = 1'b1;
        endcase
        new_cmd.mode     = qlt_pkg::mode_t'(mode);
        new_cmd.bad      = bad;
        new_cmd.cur_addr = {cur_x, cur_y, (qlt_pkg::MODE_BEST == qlt_pkg::mode_t'(mode))
                            ? 3'd0 : act};
        new_cmd.next_row = (qlt_pkg::MODE_BEST == qlt_pkg::mode_t'(mode))
                           ? {cur_x, cur_y} : {next_x, next_y};
        new_cmd.num_act  = na;
        new_cmd.alpha    = (learn_rate > qlt_pkg::ONE_Q012) ? qlt_pkg::ONE_Q012 : learn_rate;
        new_cmd.gamma    = (discount   > qlt_pkg::ONE_Q012) ? qlt_pkg::ONE_Q012 : discount;
        new_cmd.data     = data_value;
    end

    assign full      = (count_reg == (qlt_pkg::FIFO_AW+1)'(qlt_pkg::FIFO_DEPTH));
    assign do_push   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !(cmd_take && cmd_valid))
            count_next = count_reg + 1'b1;
        else if (!do_push && cmd_take && cmd_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (cmd_take && cmd_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            fifo_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

// ----- rtl/qlt_back.sv -----
// Back end: sequencer over the Q table memory, max scan and learn arithmetic.
// Depends on qlt_pkg.
module qlt_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  qlt_pkg::cmd_t         cmd,
    output logic                  cmd_take,
    output logic                  res_valid,
    output logic signed [23:0]    res_q,
    output logic [2:0]            res_act,
    output logic                  res_bad,
    input  logic                  res_take
);

    localparam int QW = qlt_pkg::Q_WIDTH;
    localparam int AW = qlt_pkg::A_W;

    logic signed [QW-1:0] mem [qlt_pkg::DEPTH];
    logic signed [QW-1:0] rd_data_reg;
    logic [qlt_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic signed [QW-1:0]       wr_data;

    qlt_pkg::state_t state_reg, state_next;
    qlt_pkg::cmd_t   cmd_reg;
    logic [AW:0]     idx_reg, idx_next;
    logic signed [QW-1:0] max_reg, max_next;
    logic [AW-1:0]        best_reg, best_next;
    logic signed [QW-1:0] old_reg, old_next;
    logic signed [QW+14:0] prod_reg, prod_next;
    logic signed [QW+2:0]  diff_reg, diff_next;
    logic signed [QW+2:0]  sum_reg, sum_next;
    logic signed [QW-1:0]  q_reg, q_next;
    logic                  out_valid_reg;
    logic signed [QW-1:0]  out_q_reg;
    logic [2:0]            out_act_reg;
    logic                  out_bad_reg;
    logic                  load_out;
    logic signed [QW+1:0]  target;
    logic signed [QW+15:0] adj;
    logic signed [QW+1:0]  sat_in;

    // Memory: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cmd_reg.cur_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qlt_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = qlt_pkg::ST_SCAN_RD;
            qlt_pkg::ST_SCAN_RD:
                if (cmd_reg.bad || cmd_reg.mode == qlt_pkg::MODE_WRITE)
                    state_next = qlt_pkg::ST_WRITE;
                else if (cmd_reg.mode == qlt_pkg::MODE_READ)
                    state_next = qlt_pkg::ST_OLD;
                else
                    state_next = qlt_pkg::ST_SCAN;
            qlt_pkg::ST_SCAN:
                if (idx_reg == cmd_reg.num_act)
                    state_next = (cmd_reg.mode == qlt_pkg::MODE_BEST)
                                 ? qlt_pkg::ST_DONE : qlt_pkg::ST_OLD_RD;
            qlt_pkg::ST_OLD_RD:  state_next = qlt_pkg::ST_OLD;
            qlt_pkg::ST_OLD:
                state_next = (cmd_reg.mode == qlt_pkg::MODE_READ)
                             ? qlt_pkg::ST_DONE : qlt_pkg::ST_MUL_G;
            qlt_pkg::ST_MUL_G:   state_next = qlt_pkg::ST_MUL_A;
            qlt_pkg::ST_MUL_A:   state_next = qlt_pkg::ST_SAT;
            qlt_pkg::ST_SAT:     state_next = qlt_pkg::ST_WRITE;
            qlt_pkg::ST_WRITE:   state_next = qlt_pkg::ST_DONE;
            qlt_pkg::ST_DONE:
                if (!out_valid_reg || res_take)
                    state_next = qlt_pkg::ST_IDLE;
            default:             state_next = qlt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_take  = (state_reg == qlt_pkg::ST_IDLE);
        rd_addr   = cmd_reg.cur_addr;
        wr_en     = 1'b0;
        wr_data   = q_reg;
        load_out  = 1'b0;
        idx_next  = idx_reg;
        max_next  = max_reg;
        best_next = best_reg;
        old_next  = old_reg;
        prod_next = prod_reg;
        diff_next = diff_reg;
        sum_next  = sum_reg;
        q_next    = q_reg;
        target    = '0;
        adj       = '0;
        sat_in    = '0;
        case (state_reg)
            qlt_pkg::ST_IDLE:
                idx_next = '0;
            qlt_pkg::ST_SCAN_RD:
            begin
                // Issue read of action 0 of the scanned row, or of the addressed entry.
                if (cmd_reg.mode == qlt_pkg::MODE_READ)
                    rd_addr = cmd_reg.cur_addr;
                else
                    rd_addr = {cmd_reg.next_row, AW'(0)};
                idx_next = (AW+1)'(1);
                if (cmd_reg.mode == qlt_pkg::MODE_WRITE)
                    q_next = cmd_reg.data;
            end
            qlt_pkg::ST_SCAN:
            begin
                rd_addr  = {cmd_reg.next_row, idx_reg[AW-1:0]};
                if (idx_reg == (AW+1)'(1) || rd_data_reg > max_reg)
                begin
                    max_next  = rd_data_reg;
                    best_next = AW'(idx_reg - 1'b1);
                end
                if (idx_reg != cmd_reg.num_act)
                    idx_next = idx_reg + 1'b1;
                q_next = (idx_reg == (AW+1)'(1) || rd_data_reg > max_reg)
                         ? rd_data_reg : max_reg;
            end
            qlt_pkg::ST_OLD_RD: ;
            qlt_pkg::ST_OLD:
            begin
                old_next  = rd_data_reg;
                q_next    = rd_data_reg;
                prod_next = (QW+15)'($signed({1'b0, cmd_reg.gamma})) * (QW+15)'(max_reg);
            end
            qlt_pkg::ST_MUL_G:
            begin
                target    = (QW+2)'(cmd_reg.data) + (QW+2)'((prod_reg + 2048) >>> 12);
                diff_next = (QW+3)'(target) - (QW+3)'(old_reg);
            end
            qlt_pkg::ST_MUL_A:
            begin
                adj      = (QW+16)'($signed({1'b0, cmd_reg.alpha})) * (QW+16)'(diff_reg);
                sum_next = (QW+3)'(old_reg) + (QW+3)'((adj + 2048) >>> 12);
            end
            qlt_pkg::ST_SAT:
            begin
                sat_in = (QW+2)'(sum_reg);
                if (sum_reg > (QW+3)'(8388607))
                    q_next = 24'sh7FFFFF;
                else if (sum_reg < -(QW+3)'(8388608))
                    q_next = -24'sh800000;
                else
                    q_next = sat_in[QW-1:0];
            end
            qlt_pkg::ST_WRITE:
                wr_en = !cmd_reg.bad;
            qlt_pkg::ST_DONE:
                load_out = (!out_valid_reg || res_take);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qlt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_valid)
            cmd_reg <= cmd;
        idx_reg  <= idx_next;
        max_reg  <= max_next;
        best_reg <= best_next;
        old_reg  <= old_next;
        prod_reg <= prod_next;
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
        q_reg    <= q_next;
        if (load_out)
        begin
            out_bad_reg <= cmd_reg.bad;
            out_q_reg   <= cmd_reg.bad ? '0 : q_reg;
            out_act_reg <= (cmd_reg.bad || cmd_reg.mode != qlt_pkg::MODE_BEST)
                           ? 3'd0 : 3'(best_reg);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_q     = out_q_reg;
    assign res_act   = out_act_reg;
    assign res_bad   = out_bad_reg;

endmodule

// ----- rtl/q_learning_table_update_core.sv -----
// Top level of the Q table update block: config registers, front end, back end.
// Depends on qlt_pkg, qlt_front and qlt_back.
//
// Input channel: push/full. A word is taken when push is high and full is low.
// Words carry mode, indexes and a data value; indexes are checked against the
// sizes in use on entry and a command is queued (two deep) for the back end.
// Result channel: empty/pop. The oldest result sits on q_out, best_act and
// bad_index while empty is low; pop with empty low takes it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Writes belong to idle periods only.
// The back end handles one word at a time and takes no new word until its
// last result has been loaded. It is paced by the single table read port
// scanning the next-state row one action per cycle for best and learn, and by
// the two multiply steps of learn.
// Reset clears the config registers to their defaults and empties all queues;
// table contents are undefined until written.
// A stalled receiver holds the result; the back end then waits with one more
// result ready, and the front queue fills and raises full.
module q_learning_table_update_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         mode,
    input  logic [2:0]         act,
    input  logic [3:0]         cur_x,
    input  logic [3:0]         cur_y,
    input  logic [3:0]         next_x,
    input  logic [3:0]         next_y,
    input  logic signed [23:0] data_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] q_out,
    output logic [2:0]         best_act,
    output logic               bad_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data
);

    logic [12:0] learn_rate_reg;
    logic [12:0] discount_reg;
    logic [3:0]  actions_reg;
    logic [4:0]  width_reg;
    logic [4:0]  height_reg;
    logic        cmd_valid;
    logic        cmd_take;
    logic        res_valid;
    qlt_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= 13'd410;
            discount_reg   <= 13'd3686;
            actions_reg    <= 4'd8;
            width_reg      <= 5'd16;
            height_reg     <= 5'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qlt_pkg::REG_LEARN_RATE: learn_rate_reg <= cfg_data;
                qlt_pkg::REG_DISCOUNT:   discount_reg   <= cfg_data;
                qlt_pkg::REG_ACTIONS:    actions_reg    <= cfg_data[3:0];
                qlt_pkg::REG_WIDTH:      width_reg      <= cfg_data[4:0];
                qlt_pkg::REG_HEIGHT:     height_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    qlt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .act            (act),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .next_x         (next_x),
        .next_y         (next_y),
        .data_value     (data_value),
        .learn_rate     (learn_rate_reg),
        .discount       (discount_reg),
        .actions_in_use (actions_reg),
        .grid_width     (width_reg),
        .grid_height    (height_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    qlt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res_q     (q_out),
        .res_act   (best_act),
        .res_bad   (bad_index),
        .res_take  (pop)
    );

    assign empty = !res_valid;

endmodule

// ----- rtl/qlt_checker.sv -----
// Port-level checks for the Q table update block, bound to the top level.
// Depends on q_learning_table_update_core ports only.
module qlt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [23:0] q_out,
    input logic [2:0]         best_act,
    input logic               bad_index
);

    // A rejected word reports no value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_index) |-> (q_out == '0 && best_act == '0))
        else $error("bad index result carries data");

    // A waiting result holds until popped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(q_out) && $stable(bad_index)))
        else $error("result changed while stalled");

    // A result on the ports is fully defined.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown({q_out, best_act, bad_index}))
        else $error("result word has unknown bits");

    // Handshake flags are always defined.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("full or empty unknown");

endmodule

bind q_learning_table_update_core qlt_checker u_qlt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .q_out     (q_out),
    .best_act  (best_act),
    .bad_index (bad_index)
);
